// ----- rtl/core/sfp_pkg.sv -----
package sfp_pkg;

	localparam int FRAME_SLOTS_DEF = 10;
	localparam int SLOT_W          = 4;
	localparam int STORE_DEPTH     = 4;

	typedef logic [7:0] byte_t;
	typedef byte_t [STORE_DEPTH-1:0] frame_t;

	localparam byte_t CHAR_SLASH  = 8'h2f;
	localparam byte_t CHAR_ZERO   = 8'h30;
	localparam byte_t CHAR_NINE   = 8'h39;
	localparam byte_t CHAR_FIRST  = 8'h41;
	localparam byte_t CHAR_LAST   = 8'h46;

	localparam logic [2:0] CH_C = 3'd2;
	localparam logic [2:0] CH_F = 3'd5;

	localparam logic [9:0] CMP_BASE = 10'd130;
	localparam logic [9:0] CMP_OFFS = 10'd80;
	localparam logic [9:0] CMP_STD  = 10'd100;

	localparam logic [6:0] SEG_ZERO = 7'h3f;

	typedef struct packed {
		logic [2:0] channel;
		logic [7:0] compare_value;
		logic [9:0] degree;
		logic [6:0] seg_thousands;
		logic [6:0] seg_hundreds;
		logic [6:0] seg_tens;
		logic [6:0] seg_units;
	} res_t;

	function automatic logic is_digit(input byte_t c);
		return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
	endfunction

	function automatic logic [6:0] seg_code(input logic [3:0] d);
		logic [6:0] s;
		case (d)
			4'd0: s = 7'h3f;
			4'd1: s = 7'h06;
			4'd2: s = 7'h5b;
			4'd3: s = 7'h4f;
			4'd4: s = 7'h66;
			4'd5: s = 7'h6d;
			4'd6: s = 7'h7d;
			4'd7: s = 7'h27;
			4'd8: s = 7'h7f;
			4'd9: s = 7'h6f;
			default: s = 7'h00;
		endcase
		return s;
	endfunction

endpackage

// ----- rtl/core/servo_command_frame_parser_unit.sv -----
// Channel   Handshake            Payload
// input     in_valid / in_stall  rx_byte[7:0]
// output    out_valid / out_stall channel, compare_value, degree, seg_* codes
//
// One byte per cycle while in_stall is low; a '/' passes from the input register
// through decode into the result register, which then raises out_valid.
// Rate is set by the input register feeding decode into the result register.
// Reset clears the frame store, slot index and both valid flags.
// A stalled result blocks only a '/' that completes a good frame; other bytes
// keep flowing into the frame store.
module servo_command_frame_parser_unit #(
	parameter int FRAME_SLOTS = sfp_pkg::FRAME_SLOTS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [2:0] channel,
	output logic [7:0] compare_value,
	output logic [9:0] degree,
	output logic [6:0] seg_thousands,
	output logic [6:0] seg_hundreds,
	output logic [6:0] seg_tens,
	output logic [6:0] seg_units
);

	logic            valid_s1;
	sfp_pkg::byte_t  rx_s1;
	logic            advance;
	logic            hit;
	sfp_pkg::frame_t frame_nx;
	sfp_pkg::res_t   res;
	sfp_pkg::res_t   res_q;
	logic            res_valid_q;

	sfp_frame_store #(
		.FRAME_SLOTS(FRAME_SLOTS)
	) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (advance),
		.rx_data (rx_s1),
		.frame_nx(frame_nx)
	);

	sfp_decode u_decode (
		.frame  (frame_nx),
		.rx_data(rx_s1),
		.hit    (hit),
		.res    (res)
	);

	// hold a result-producing byte only while the result slot is stuck
	assign advance  = valid_s1 && (!hit || !res_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			rx_s1 <= rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance && hit) begin
			res_valid_q <= 1'b1;
		end else if (!out_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && hit) begin
			res_q <= res;
		end
	end

	assign out_valid     = res_valid_q;
	assign channel       = res_q.channel;
	assign compare_value = res_q.compare_value;
	assign degree        = res_q.degree;
	assign seg_thousands = res_q.seg_thousands;
	assign seg_hundreds  = res_q.seg_hundreds;
	assign seg_tens      = res_q.seg_tens;
	assign seg_units     = res_q.seg_units;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		!(advance && hit && res_valid_q && out_stall))
		else $error("pending result overwritten");

	a_accept_loads: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> valid_s1)
		else $error("accepted request lost at input register");

	a_result_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> degree <= 10'd999 && channel <= sfp_pkg::CH_F
			&& seg_thousands == sfp_pkg::SEG_ZERO)
		else $error("result fields out of range");

endmodule

// ----- rtl/core/sfp_frame_store.sv -----
module sfp_frame_store #(
	parameter int FRAME_SLOTS = sfp_pkg::FRAME_SLOTS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_en,
	input  sfp_pkg::byte_t rx_data,
	output sfp_pkg::frame_t frame_nx
);

	localparam logic [sfp_pkg::SLOT_W-1:0] LAST_SLOT = sfp_pkg::SLOT_W'(FRAME_SLOTS - 1);

	sfp_pkg::frame_t              frame_q;
	logic [sfp_pkg::SLOT_W-1:0]   slot_q;

	// frame as it stands once the current byte is stored
	always_comb begin
		frame_nx = frame_q;
		if (slot_q < sfp_pkg::SLOT_W'(sfp_pkg::STORE_DEPTH)) begin
			frame_nx[slot_q[1:0]] = rx_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_q <= '0;
			slot_q  <= '0;
		end else if (wr_en) begin
			frame_q <= frame_nx;
			if (rx_data == sfp_pkg::CHAR_SLASH || slot_q >= LAST_SLOT) begin
				slot_q <= '0;
			end else begin
				slot_q <= slot_q + sfp_pkg::SLOT_W'(1);
			end
		end
	end

	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		slot_q <= LAST_SLOT)
		else $error("slot index past last slot");

	a_slash_restart: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en && rx_data == sfp_pkg::CHAR_SLASH |=> slot_q == '0)
		else $error("slot index did not restart after frame end");

endmodule

// ----- rtl/core/sfp_decode.sv -----
module sfp_decode (
	input  sfp_pkg::frame_t frame,
	input  sfp_pkg::byte_t  rx_data,
	output logic            hit,
	output sfp_pkg::res_t   res
);

	logic [3:0] h, t, u;
	logic [9:0] deg;
	logic [2:0] ch;
	logic       letter_ok;
	logic       digits_ok;

	always_comb begin
		letter_ok = (frame[0] >= sfp_pkg::CHAR_FIRST) && (frame[0] <= sfp_pkg::CHAR_LAST);
		digits_ok = sfp_pkg::is_digit(frame[1]) && sfp_pkg::is_digit(frame[2])
			&& sfp_pkg::is_digit(frame[3]);
		hit = (rx_data == sfp_pkg::CHAR_SLASH) && letter_ok && digits_ok;

		ch = 3'(frame[0] - sfp_pkg::CHAR_FIRST);
		h  = 4'(frame[1] - sfp_pkg::CHAR_ZERO);
		t  = 4'(frame[2] - sfp_pkg::CHAR_ZERO);
		u  = 4'(frame[3] - sfp_pkg::CHAR_ZERO);
		deg = 10'(h) * 10'd100 + 10'(t) * 10'd10 + 10'(u);

		res.channel = ch;
		res.degree  = deg;
		// compare value wraps mod 256
		case (ch)
			sfp_pkg::CH_C: res.compare_value = 8'(sfp_pkg::CMP_BASE + sfp_pkg::CMP_OFFS - deg);
			sfp_pkg::CH_F: res.compare_value = 8'(deg + sfp_pkg::CMP_OFFS);
			default:       res.compare_value = 8'(sfp_pkg::CMP_BASE + sfp_pkg::CMP_STD - deg);
		endcase
		res.seg_thousands = sfp_pkg::SEG_ZERO;
		res.seg_hundreds  = sfp_pkg::seg_code(h);
		res.seg_tens      = sfp_pkg::seg_code(t);
		res.seg_units     = sfp_pkg::seg_code(u);
	end

endmodule
